@@ rtl/core/fgc_pkg.sv @@
package fgc_pkg;

  // Event codes
  localparam logic [1:0] FUNC_BEGIN  = 2'd0;
  localparam logic [1:0] FUNC_UPDATE = 2'd1;
  localparam logic [1:0] FUNC_END    = 2'd2;

  // Direction codes
  localparam logic [3:0] DIR_NONE = 4'd0;
  localparam logic [3:0] DIR_S    = 4'd2;
  localparam logic [3:0] DIR_SE   = 4'd3;
  localparam logic [3:0] DIR_E    = 4'd4;
  localparam logic [3:0] DIR_NE   = 4'd5;
  localparam logic [3:0] DIR_N    = 4'd6;
  localparam logic [3:0] DIR_NW   = 4'd7;
  localparam logic [3:0] DIR_W    = 4'd8;
  localparam logic [3:0] DIR_SW   = 4'd9;

  // Configuration register indexes
  localparam logic [2:0] CFG_MM_PER_PX_X = 3'd0;
  localparam logic [2:0] CFG_MM_PER_PX_Y = 3'd1;
  localparam logic [2:0] CFG_DIST_MIN_MM = 3'd2;
  localparam logic [2:0] CFG_DIST_MAX_MM = 3'd3;
  localparam logic [2:0] CFG_RATIO_MIN   = 3'd4;
  localparam logic [2:0] CFG_RATIO_MAX   = 3'd5;
  localparam logic [2:0] CFG_TIMEOUT_MS  = 3'd6;
  localparam logic [2:0] CFG_EIGHT_WAY   = 3'd7;

  // Configuration reset values
  localparam logic [15:0] RST_MM_PER_PX_X = 16'd24366;
  localparam logic [15:0] RST_MM_PER_PX_Y = 16'd8024;
  localparam logic [15:0] RST_DIST_MIN_MM = 16'd1280;
  localparam logic [15:0] RST_DIST_MAX_MM = 16'd25600;
  localparam logic [7:0]  RST_RATIO_MIN   = 8'd10;
  localparam logic [7:0]  RST_RATIO_MAX   = 8'd35;
  localparam logic [15:0] RST_TIMEOUT_MS  = 16'd500;
  localparam logic        RST_EIGHT_WAY   = 1'b0;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [23:0] delta_x;
    logic signed [23:0] delta_y;
    logic signed [23:0] speed_x;
    logic signed [23:0] speed_y;
    logic [31:0]        time_ms;
  } evt_t;

  typedef struct packed {
    logic        is_flick;
    logic [3:0]  direction;
    logic [15:0] dist_x_mm;
    logic [15:0] dist_y_mm;
    logic [31:0] duration_ms;
  } res_t;

  typedef struct packed {
    logic [15:0] mm_per_px_x;
    logic [15:0] mm_per_px_y;
    logic [15:0] dist_min_mm;
    logic [15:0] dist_max_mm;
    logic [7:0]  ratio_min;
    logic [7:0]  ratio_max;
    logic [15:0] timeout_ms;
    logic        eight_way;
  } cfg_t;

  // One operation of the shared multiplier per cycle, in this order
  typedef enum logic [3:0] {
    OP_AX,
    OP_AY,
    OP_VX,
    OP_VY,
    OP_AX2,
    OP_AY2,
    OP_VX2,
    OP_VY2,
    OP_SUMS,
    OP_RMAX_SQ,
    OP_RMAX_V,
    OP_RMIN_SQ,
    OP_RMIN_V,
    OP_DMAX_SQ,
    OP_DMIN_SQ,
    OP_FINISH
  } op_e;

  typedef struct packed {
    logic load;
    logic apply;
    logic calc;
    op_e  op;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_end;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/core/fgc_ctrl.sv @@
module fgc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             evt_valid,
  output logic             evt_stall,
  input  fgc_pkg::dp_stat_t stat,
  output fgc_pkg::dp_cmd_t  cmd
);
  import fgc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_APPLY = 4'b0010,
    ST_CALC  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e state, state_next;
  op_e    op_q, op_next;

  // Sequence one request: latch, apply or calculate, then hand to the output register
  always_comb begin
    state_next = state;
    op_next    = op_q;
    cmd        = '0;
    cmd.op     = op_q;
    evt_stall  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        evt_stall = 1'b0;
        if (evt_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        op_next = OP_AX;
        if (stat.is_end) begin
          state_next = ST_CALC;
        end else begin
          cmd.apply  = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        if (op_q == OP_FINISH) begin
          state_next = ST_EMIT;
        end else begin
          op_next = op_e'(op_q + 4'd1);
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Advance state and operation step
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op_q  <= OP_AX;
    end else begin
      state <= state_next;
      op_q  <= op_next;
    end
  end

`ifndef SYNTH
  a_accept_to_apply: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && !evt_stall) |=> (state == ST_APPLY))
    else $error("accepted request did not move to apply");

  a_finish_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC && op_q == OP_FINISH) |=> (state == ST_EMIT))
    else $error("last calculation step did not move to emit");

  a_apply_short: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY && !stat.is_end) |=> (state == ST_EMIT))
    else $error("begin or update did not go straight to emit");

  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !stat.out_free) |=> (state == ST_EMIT))
    else $error("emit left while output register was occupied");
`endif

endmodule

@@ rtl/core/fgc_dp.sv @@
module fgc_dp (
  input  logic              clk,
  input  logic              rst,
  input  fgc_pkg::evt_t     evt,
  input  fgc_pkg::cfg_t     cfg,
  input  fgc_pkg::dp_cmd_t  cmd,
  output fgc_pkg::dp_stat_t stat,
  output logic              res_valid,
  input  logic              res_stall,
  output fgc_pkg::res_t     res
);
  import fgc_pkg::*;

  evt_t        evt_q;
  logic [31:0] sum_dx, sum_dy, sum_speed_x, sum_speed_y, start_time;

  logic [31:0] ax, ay, vx, vy;
  logic [63:0] ax2, ay2, vx2, vy2;
  logic [31:0] d2c, v2c;
  logic [15:0] rsq;
  logic [47:0] lim_hi, lim_lo;
  logic [31:0] dmax2, dmin2;
  res_t        res_q;

  logic [31:0] mag_dx, mag_dy;
  logic [23:0] abs_vx, abs_vy;
  logic [32:0] add_dx, add_dy, add_sx, add_sy;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [64:0] d2_sum, v2_sum;
  logic [31:0] dur;
  logic        west, north, flick;
  logic [65:0] ay2_x3, ax2_x3;
  logic [3:0]  dir;
  logic [15:0] whole_x, whole_y;

  assign stat.is_end   = (evt_q.func == FUNC_END);
  assign stat.out_free = !res_valid || !res_stall;

  // Magnitudes and saturating sums for the accumulators
  assign mag_dx = sum_dx[31] ? (~sum_dx + 32'd1) : sum_dx;
  assign mag_dy = sum_dy[31] ? (~sum_dy + 32'd1) : sum_dy;
  assign abs_vx = evt_q.speed_x[23] ? (~evt_q.speed_x + 24'd1) : evt_q.speed_x;
  assign abs_vy = evt_q.speed_y[23] ? (~evt_q.speed_y + 24'd1) : evt_q.speed_y;
  assign add_dx = {sum_dx[31], sum_dx} + {{9{evt_q.delta_x[23]}}, evt_q.delta_x};
  assign add_dy = {sum_dy[31], sum_dy} + {{9{evt_q.delta_y[23]}}, evt_q.delta_y};
  assign add_sx = {1'b0, sum_speed_x} + {9'd0, abs_vx};
  assign add_sy = {1'b0, sum_speed_y} + {9'd0, abs_vy};

  // Select operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_AX:      begin mul_a = mag_dx;       mul_b = {16'd0, cfg.mm_per_px_x}; end
      OP_AY:      begin mul_a = mag_dy;       mul_b = {16'd0, cfg.mm_per_px_y}; end
      OP_VX:      begin mul_a = sum_speed_x;  mul_b = {16'd0, cfg.mm_per_px_x}; end
      OP_VY:      begin mul_a = sum_speed_y;  mul_b = {16'd0, cfg.mm_per_px_y}; end
      OP_AX2:     begin mul_a = ax;           mul_b = ax; end
      OP_AY2:     begin mul_a = ay;           mul_b = ay; end
      OP_VX2:     begin mul_a = vx;           mul_b = vx; end
      OP_VY2:     begin mul_a = vy;           mul_b = vy; end
      OP_RMAX_SQ: begin mul_a = {24'd0, cfg.ratio_max}; mul_b = {24'd0, cfg.ratio_max}; end
      OP_RMAX_V:  begin mul_a = {16'd0, rsq}; mul_b = v2c; end
      OP_RMIN_SQ: begin mul_a = {24'd0, cfg.ratio_min}; mul_b = {24'd0, cfg.ratio_min}; end
      OP_RMIN_V:  begin mul_a = {16'd0, rsq}; mul_b = v2c; end
      OP_DMAX_SQ: begin mul_a = {16'd0, cfg.dist_max_mm}; mul_b = {16'd0, cfg.dist_max_mm}; end
      OP_DMIN_SQ: begin mul_a = {16'd0, cfg.dist_min_mm}; mul_b = {16'd0, cfg.dist_min_mm}; end
      OP_SUMS, OP_FINISH: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  // Sums of squares, held at all ones: any passing distance squared stays below
  // the square of the largest maximum distance, so the verdicts are unchanged
  assign d2_sum = {1'b0, ax2} + {1'b0, ay2};
  assign v2_sum = {1'b0, vx2} + {1'b0, vy2};

  // Verdict and direction
  assign dur    = evt_q.time_ms - start_time;
  assign west   = sum_dx[31];
  assign north  = sum_dy[31];
  assign ay2_x3 = {1'b0, ay2, 1'b0} + {2'b00, ay2};
  assign ax2_x3 = {1'b0, ax2, 1'b0} + {2'b00, ax2};

  assign flick = (d2c != 32'd0) && (v2c != 32'd0)
              && (d2c <= dmax2) && (d2c >= dmin2)
              && ({16'd0, d2c} <= lim_hi) && ({16'd0, d2c} >= lim_lo)
              && (dur <= {16'd0, cfg.timeout_ms});

  always_comb begin
    dir = DIR_NONE;
    if (flick) begin
      if (!cfg.eight_way) begin
        if (ay < ax) dir = west ? DIR_W : DIR_E;
        else         dir = north ? DIR_N : DIR_S;
      end else begin
        priority if (ay2_x3 < {2'b00, ax2}) dir = west ? DIR_W : DIR_E;
        else if ({2'b00, ay2} > ax2_x3)     dir = north ? DIR_N : DIR_S;
        else if (!west && !north)           dir = DIR_SE;
        else if (west && north)             dir = DIR_NW;
        else if (!west && north)            dir = DIR_NE;
        else                                dir = DIR_SW;
      end
    end
  end

  assign whole_x = (|ax[31:24]) ? 16'hFFFF : ax[23:8];
  assign whole_y = (|ay[31:24]) ? 16'hFFFF : ay[23:8];

  // Hold the latched request
  always_ff @(posedge clk) begin
    if (cmd.load) evt_q <= evt;
  end

  // Accumulators: clear on begin, saturating add on update
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_dx      <= '0;
      sum_dy      <= '0;
      sum_speed_x <= '0;
      sum_speed_y <= '0;
      start_time  <= '0;
    end else if (cmd.apply) begin
      if (evt_q.func == FUNC_BEGIN) begin
        sum_dx      <= '0;
        sum_dy      <= '0;
        sum_speed_x <= '0;
        sum_speed_y <= '0;
        start_time  <= evt_q.time_ms;
      end else if (evt_q.func == FUNC_UPDATE) begin
        sum_dx <= (add_dx[32] != add_dx[31]) ?
                  (add_dx[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : add_dx[31:0];
        sum_dy <= (add_dy[32] != add_dy[31]) ?
                  (add_dy[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : add_dy[31:0];
        sum_speed_x <= add_sx[32] ? 32'hFFFF_FFFF : add_sx[31:0];
        sum_speed_y <= add_sy[32] ? 32'hFFFF_FFFF : add_sy[31:0];
      end
    end
  end

  // Store each step's product or sums, and the verdict at the last step; apply clears the result
  always_ff @(posedge clk) begin
    if (cmd.apply) res_q <= '0;
    if (cmd.calc) begin
      unique case (cmd.op)
        OP_AX:      ax     <= prod[47:16];
        OP_AY:      ay     <= prod[47:16];
        OP_VX:      vx     <= prod[47:16];
        OP_VY:      vy     <= prod[47:16];
        OP_AX2:     ax2    <= prod;
        OP_AY2:     ay2    <= prod;
        OP_VX2:     vx2    <= prod;
        OP_VY2:     vy2    <= prod;
        OP_SUMS: begin
          d2c <= (|d2_sum[64:32]) ? 32'hFFFF_FFFF : d2_sum[31:0];
          v2c <= (|v2_sum[64:32]) ? 32'hFFFF_FFFF : v2_sum[31:0];
        end
        OP_RMAX_SQ: rsq    <= prod[15:0];
        OP_RMAX_V:  lim_hi <= prod[47:0];
        OP_RMIN_SQ: rsq    <= prod[15:0];
        OP_RMIN_V:  lim_lo <= prod[47:0];
        OP_DMAX_SQ: dmax2  <= prod[31:0];
        OP_DMIN_SQ: dmin2  <= prod[31:0];
        OP_FINISH: begin
          res_q.is_flick    <= flick;
          res_q.direction   <= dir;
          res_q.dist_x_mm   <= whole_x;
          res_q.dist_y_mm   <= whole_y;
          res_q.duration_ms <= dur;
        end
      endcase
    end
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) res <= res_q;
  end

endmodule

@@ rtl/core/flick_gesture_classifier_top.sv @@
// Flick classifier for single-finger drags.
// Event channel (evt_valid, evt_stall, evt): one drag event per request, begin,
// update or end. Result channel (res_valid, res_stall, res): exactly one result
// per event; begin, update and unknown codes give an all-zero result.
// Configuration: write cfg_data to register cfg_index while cfg_we is high,
// only while the block is idle. Indexes follow the package CFG_ constants.
// Each event is processed to completion before the next is accepted: evt_stall
// stays high from acceptance until its result is handed to the output register.
// End events take longer than begin/update, set by the
// single shared 32x32 multiplier, which runs the scaling, squaring and limit
// products one per cycle under the controller's step sequence.
// A finished result sits in the output register; the next event is taken while
// it waits, and is held back only before its own result would overwrite it.
// While res_stall is high and a result is valid, res holds and no further result is loaded.
// Reset (rst, synchronous) clears the sums and start time, empties the output
// register and restores the register defaults.
module flick_gesture_classifier_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           evt_valid,
  output logic           evt_stall,
  input  fgc_pkg::evt_t  evt,
  output logic           res_valid,
  input  logic           res_stall,
  output fgc_pkg::res_t  res,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import fgc_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mm_per_px_x <= RST_MM_PER_PX_X;
      cfg.mm_per_px_y <= RST_MM_PER_PX_Y;
      cfg.dist_min_mm <= RST_DIST_MIN_MM;
      cfg.dist_max_mm <= RST_DIST_MAX_MM;
      cfg.ratio_min   <= RST_RATIO_MIN;
      cfg.ratio_max   <= RST_RATIO_MAX;
      cfg.timeout_ms  <= RST_TIMEOUT_MS;
      cfg.eight_way   <= RST_EIGHT_WAY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MM_PER_PX_X: cfg.mm_per_px_x <= cfg_data;
        CFG_MM_PER_PX_Y: cfg.mm_per_px_y <= cfg_data;
        CFG_DIST_MIN_MM: cfg.dist_min_mm <= cfg_data;
        CFG_DIST_MAX_MM: cfg.dist_max_mm <= cfg_data;
        CFG_RATIO_MIN:   cfg.ratio_min   <= cfg_data[7:0];
        CFG_RATIO_MAX:   cfg.ratio_max   <= cfg_data[7:0];
        CFG_TIMEOUT_MS:  cfg.timeout_ms  <= cfg_data;
        CFG_EIGHT_WAY:   cfg.eight_way   <= cfg_data[0];
      endcase
    end
  end

  fgc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  fgc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
